// ===== rtl/rcw_pkg.sv =====
// Shared types, constants and the initial window function of the Reno
// congestion window unit. No dependencies.
package rcw_pkg;

  localparam int DefaultCountWidth = 32;
  localparam int MssWidth          = 16;
  localparam int DataWidth         = 32;
  localparam int ProdWidth         = MssWidth + DataWidth;
  localparam int InitWidth         = 20;

  localparam logic [MssWidth-1:0]  MssDefault   = 16'd1200;
  localparam logic [InitWidth-1:0] InitFloor    = 20'd14720;
  localparam logic [InitWidth-1:0] InitSegments = 20'd10;
  localparam logic [InitWidth-1:0] MinSegments  = 20'd2;

  typedef enum logic [1:0] {
    ModeAck        = 2'd0,
    ModeLoss       = 2'd1,
    ModePersistent = 2'd2,
    ModeQuery      = 2'd3
  } mode_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [InitWidth-1:0] init_window(input logic [MssWidth-1:0] mss);
    logic [InitWidth-1:0] a;
    logic [InitWidth-1:0] b;
    a = InitWidth'(mss) * InitSegments;
    b = InitWidth'(mss) * MinSegments;
    if (b < InitFloor) begin
      b = InitFloor;
    end
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/reno_congestion_window_unit.sv =====
// Top level of the Reno congestion window unit: event sequencer, window
// and threshold registers, output register.
// Depends on rcw_pkg and rcw_div.
//
// Usage:
//   Event channel (in_valid_i/in_ready_o) carries mode, bytes acked and
//   bytes in flight. Result channel (out_valid_o/out_ready_i) returns the
//   window, threshold, send-allowed and slow-start flags, one transaction
//   per event. The configuration channel (cfg_valid_i/cfg_ready_o) writes
//   the segment size and re-initialises window and threshold; it is
//   ready only while the unit is idle.
//   An ack in congestion avoidance waits for one 48-step pass of the
//   bit-serial divider for mss*acked/window; every other event goes
//   from the execute state straight to the result. One event is in work
//   at a time; in_ready_o rises again in the same cycle as the result is
//   registered, so a new event is taken only once the last one is done.
//   Reset: segment size 1200, window 12000, threshold all ones.
//   A stalled receiver holds the result register; the sequencer waits
//   with the next result until that transaction completes.
module reno_congestion_window_unit #(
  parameter int CountWidth = rcw_pkg::DefaultCountWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rcw_pkg::MssWidth-1:0]   cfg_max_segment_size_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic [rcw_pkg::DataWidth-1:0]  bytes_acked_i,
  input  logic [rcw_pkg::DataWidth-1:0]  bytes_in_flight_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rcw_pkg::DataWidth-1:0]  window_bytes_o,
  output logic [rcw_pkg::DataWidth-1:0]  threshold_bytes_o,
  output logic                           send_allowed_o,
  output logic                           in_slow_start_o
);

  localparam int PW       = rcw_pkg::ProdWidth;
  localparam int DW       = rcw_pkg::DataWidth;
  localparam int MW       = rcw_pkg::MssWidth;
  localparam int SumWidth = ((CountWidth > PW) ? CountWidth : PW) + 1;
  localparam int CmpWidth = (CountWidth > DW) ? CountWidth : DW;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StDivStart,
    StDivWait,
    StDone
  } state_e;

  function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] a,
                                                    input logic [PW-1:0] b);
    logic [SumWidth-1:0] sum;
    sum = SumWidth'(a) + SumWidth'(b);
    return (sum > SumWidth'(CountMax)) ? CountMax : CountWidth'(sum);
  endfunction

  function automatic logic [CountWidth-1:0] sat_data(input logic [DW-1:0] v);
    logic [CmpWidth-1:0] ext;
    ext = CmpWidth'(v);
    return (ext > CmpWidth'(CountMax)) ? CountMax : CountWidth'(ext);
  endfunction

  function automatic logic [DW-1:0] sat_out(input logic [CountWidth-1:0] v);
    logic [CmpWidth-1:0] ext;
    ext = CmpWidth'(v);
    return (ext > CmpWidth'({DW{1'b1}})) ? {DW{1'b1}} : DW'(ext);
  endfunction

  state_e                state_q, state_d;
  rcw_pkg::mode_e        mode_q, mode_d;
  logic [DW-1:0]         acked_q, acked_d;
  logic [DW-1:0]         flight_q, flight_d;
  logic [MW-1:0]         mss_q, mss_d;
  logic [CountWidth-1:0] window_q, window_d;
  logic [CountWidth-1:0] thresh_q, thresh_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic                  out_valid_q, out_valid_d;
  logic [DW-1:0]         win_out_q, win_out_d;
  logic [DW-1:0]         thr_out_q, thr_out_d;
  logic                  send_q, send_d;
  logic                  slow_q, slow_d;

  logic                  in_fire;
  logic                  cfg_fire;
  logic                  div_start;
  logic [PW-1:0]         quotient;
  rcw_pkg::div_status_t  div_status;
  logic [MW-1:0]         cfg_mss;
  logic [DW-1:0]         loss_val;
  logic [DW-1:0]         floor2;
  logic [PW-1:0]         inc;

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign div_start   = (state_q == StDivStart);

  rcw_div #(
    .CountWidth (CountWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (window_q),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    acked_d     = acked_q;
    flight_d    = flight_q;
    mss_d       = mss_q;
    window_d    = window_q;
    thresh_d    = thresh_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    win_out_d   = win_out_q;
    thr_out_d   = thr_out_q;
    send_d      = send_q;
    slow_d      = slow_q;

    cfg_mss  = (cfg_max_segment_size_i == '0) ? rcw_pkg::MssDefault : cfg_max_segment_size_i;
    floor2   = DW'(mss_q) << 1;
    loss_val = ((flight_q >> 1) > floor2) ? (flight_q >> 1) : floor2;
    inc      = (window_q == '0) ? prod_q : quotient;
    if (inc == '0) begin
      inc = PW'(1);
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (cfg_fire) begin
          mss_d    = cfg_mss;
          window_d = CountWidth'(rcw_pkg::init_window(cfg_mss));
          thresh_d = CountMax;
        end
        if (in_fire) begin
          mode_d   = rcw_pkg::mode_e'(mode_i);
          acked_d  = bytes_acked_i;
          flight_d = bytes_in_flight_i;
          state_d  = StExec;
        end
      end
      StExec: begin
        state_d = StDone;
        unique case (mode_q)
          rcw_pkg::ModeAck: begin
            if (acked_q != '0) begin
              if (window_q < thresh_q) begin
                window_d = sat_add(window_q, PW'(acked_q));
              end else begin
                prod_d  = PW'(mss_q) * PW'(acked_q);
                state_d = StDivStart;
              end
            end
          end
          rcw_pkg::ModeLoss: begin
            window_d = sat_data(loss_val);
            thresh_d = sat_data(loss_val);
          end
          rcw_pkg::ModePersistent: begin
            window_d = sat_data(floor2);
            thresh_d = sat_data(floor2);
          end
          rcw_pkg::ModeQuery: begin
          end
          default: begin
          end
        endcase
      end
      StDivStart: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_status.done) begin
          window_d = sat_add(window_q, inc);
          state_d  = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          win_out_d   = sat_out(window_q);
          thr_out_d   = sat_out(thresh_q);
          send_d      = CmpWidth'(flight_q) < CmpWidth'(window_q);
          slow_d      = window_q < thresh_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mss_q       <= rcw_pkg::MssDefault;
      window_q    <= CountWidth'(rcw_pkg::init_window(rcw_pkg::MssDefault));
      thresh_q    <= CountMax;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mss_q       <= mss_d;
      window_q    <= window_d;
      thresh_q    <= thresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    acked_q   <= acked_d;
    flight_q  <= flight_d;
    prod_q    <= prod_d;
    win_out_q <= win_out_d;
    thr_out_q <= thr_out_d;
    send_q    <= send_d;
    slow_q    <= slow_d;
  end

  assign out_valid_o       = out_valid_q;
  assign window_bytes_o    = win_out_q;
  assign threshold_bytes_o = thr_out_q;
  assign send_allowed_o    = send_q;
  assign in_slow_start_o   = slow_q;

  a_div_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> state_q == StDivWait)
    else $error("divider finished outside its wait state");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("accepted a second event while one is in work");

  a_window_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_q != '0)
    else $error("congestion window reached zero");

endmodule

// ===== rtl/rcw_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rcw_pkg.
module rcw_div #(
  parameter int CountWidth = rcw_pkg::DefaultCountWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rcw_pkg::ProdWidth-1:0] dividend_i,
  input  logic [CountWidth-1:0]        divisor_i,
  output logic [rcw_pkg::ProdWidth-1:0] quotient_o,
  output rcw_pkg::div_status_t         status_o
);

  localparam int PW       = rcw_pkg::ProdWidth;
  localparam int CntWidth = $clog2(PW + 1);

  logic [CountWidth-1:0] rem_q, rem_d;
  logic [CountWidth-1:0] dsr_q, dsr_d;
  logic [PW-1:0]         quo_q, quo_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CountWidth:0]   rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[PW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = CntWidth'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? CountWidth'(rem_sh - {1'b0, dsr_q}) : rem_sh[CountWidth-1:0];
      quo_d = {quo_q[PW-2:0], ge};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
